### rtl/core/rsv_pkg.sv
package rsv_pkg;

	localparam int CH_W  = 8;
	localparam int HUE_W = 9;
	localparam int PCT_W = 7;

	localparam int DIV_QW = 9;
	localparam int DIV_VW = 8;
	localparam int DIV_RW = DIV_VW + DIV_QW;

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	typedef struct packed {
		logic [DIV_RW-1:0] rem;
		logic [DIV_VW-1:0] den;
		logic [DIV_QW-1:0] quo;
	} div_lane_t;

endpackage

### rtl/core/rsv_div.sv
module rsv_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [rsv_pkg::DIV_RW-1:0] hue_num,
	input  logic [rsv_pkg::DIV_VW-1:0] hue_den,
	input  logic [rsv_pkg::DIV_RW-1:0] sat_num,
	input  logic [rsv_pkg::DIV_VW-1:0] sat_den,
	input  logic [rsv_pkg::PCT_W-1:0]  val_in,
	output logic                      out_valid,
	output logic [rsv_pkg::DIV_QW-1:0] hue_q,
	output logic [rsv_pkg::DIV_QW-1:0] sat_q,
	output logic [rsv_pkg::PCT_W-1:0]  val_out
);
	import rsv_pkg::*;

	logic             vld_s    [DIV_QW+1];
	div_lane_t        hue_s    [DIV_QW+1];
	div_lane_t        sat_s    [DIV_QW+1];
	logic [PCT_W-1:0] val_s    [DIV_QW+1];

	assign vld_s[0] = in_valid;
	assign hue_s[0] = '{rem: hue_num, den: hue_den, quo: '0};
	assign sat_s[0] = '{rem: sat_num, den: sat_den, quo: '0};
	assign val_s[0] = val_in;

	// one quotient bit per stage, msb first
	for (genvar k = 0; k < DIV_QW; k++) begin : g_stage
		localparam int SH = DIV_QW - 1 - k;
		logic [DIV_RW-1:0] htrial;
		logic [DIV_RW-1:0] strial;
		logic              hge;
		logic              sge;
		div_lane_t         hnext;
		div_lane_t         snext;

		always_comb begin
			htrial = DIV_RW'(hue_s[k].den) << SH;
			strial = DIV_RW'(sat_s[k].den) << SH;
			hge    = hue_s[k].rem >= htrial;
			sge    = sat_s[k].rem >= strial;
			hnext  = hue_s[k];
			snext  = sat_s[k];
			if (hge) begin
				hnext.rem = hue_s[k].rem - htrial;
			end
			if (sge) begin
				snext.rem = sat_s[k].rem - strial;
			end
			hnext.quo[SH] = hge;
			snext.quo[SH] = sge;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			hue_s[k+1] <= hnext;
			sat_s[k+1] <= snext;
			val_s[k+1] <= val_s[k];
		end
	end

	// zero divisor: gray pixel for hue, black pixel for saturation
	assign out_valid = vld_s[DIV_QW];
	assign hue_q     = (hue_s[DIV_QW].den == '0) ? '0 : hue_s[DIV_QW].quo;
	assign sat_q     = (sat_s[DIV_QW].den == '0) ? '0 : sat_s[DIV_QW].quo;
	assign val_out   = val_s[DIV_QW];

endmodule

### rtl/core/rgb_to_hsv_converter_unit.sv
// Channel   Ports                          Handshake
// request   red_in, green_in, blue_in      start, busy (busy is always low)
// result    hue_deg, sat_pct, val_pct      done, one cycle, no backpressure
//
// One pixel per clock through two front stages (max/min/sector,
// then numerators and value) and nine divider stages, one quotient bit each.
// arst_n clears the valid bits only; payload registers are not reset.
// The result side cannot stall, so the pipeline never holds and busy stays low.
module rgb_to_hsv_converter_unit (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [rsv_pkg::CH_W-1:0]  red_in,
	input  logic [rsv_pkg::CH_W-1:0]  green_in,
	input  logic [rsv_pkg::CH_W-1:0]  blue_in,
	output logic                      done,
	output logic [rsv_pkg::HUE_W-1:0] hue_deg,
	output logic [rsv_pkg::PCT_W-1:0] sat_pct,
	output logic [rsv_pkg::PCT_W-1:0] val_pct
);
	import rsv_pkg::*;

	localparam int LAT = 2 + DIV_QW;

	assign busy = 1'b0;

	// stage 1: max, min, sector, signed difference
	logic              blue_max;
	logic              green_max;
	sector_t           sec;
	logic [CH_W-1:0]   mx;
	logic [CH_W-1:0]   mn;
	logic signed [8:0] num;

	always_comb begin
		blue_max  = (blue_in >= red_in) && (blue_in >= green_in);
		green_max = (green_in >= red_in);
		if (blue_max) begin
			sec = SEC_BLUE;
			mx  = blue_in;
			num = $signed({1'b0, red_in}) - $signed({1'b0, green_in});
		end else if (green_max) begin
			sec = SEC_GREEN;
			mx  = green_in;
			num = $signed({1'b0, blue_in}) - $signed({1'b0, red_in});
		end else begin
			sec = SEC_RED;
			mx  = red_in;
			num = $signed({1'b0, green_in}) - $signed({1'b0, blue_in});
		end
		mn = red_in;
		if (green_in < mn) begin
			mn = green_in;
		end
		if (blue_in < mn) begin
			mn = blue_in;
		end
	end

	logic              vld_s1;
	sector_t           sec_s1;
	logic [CH_W-1:0]   mx_s1;
	logic [CH_W-1:0]   mn_s1;
	logic signed [8:0] num_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		sec_s1 <= sec;
		mx_s1  <= mx;
		mn_s1  <= mn;
		num_s1 <= num;
	end

	// stage 2: hue numerator 60*num + off*d, saturation numerator, value
	logic [CH_W-1:0]    d;
	logic [8:0]         off;
	logic [16:0]        off_d;
	logic signed [17:0] num60;
	logic signed [17:0] hue_n;
	logic [14:0]        mx100;
	logic [15:0]        val_sum;

	always_comb begin
		d = mx_s1 - mn_s1;
		case (sec_s1)
			SEC_BLUE:  off = 9'd240;
			SEC_GREEN: off = 9'd120;
			SEC_RED:   off = num_s1[8] ? 9'd360 : 9'd0;
			default:   off = 9'd0;
		endcase
		off_d   = 17'(off) * 17'(d);
		num60   = num_s1 * 18'sd60;
		hue_n   = num60 + $signed({1'b0, off_d});
		mx100   = 15'(mx_s1) * 15'd100;
		// floor(x/255) for x below 32640, where the quotient fits in 7 bits
		val_sum = 16'(mx100) + 16'd1 + 16'(mx100[14:8]);
	end

	logic               vld_s2;
	logic [DIV_RW-1:0]  hue_num_s2;
	logic [DIV_VW-1:0]  hue_den_s2;
	logic [DIV_RW-1:0]  sat_num_s2;
	logic [DIV_VW-1:0]  sat_den_s2;
	logic [PCT_W-1:0]   val_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		hue_num_s2 <= hue_n[DIV_RW-1:0];
		hue_den_s2 <= d;
		sat_num_s2 <= DIV_RW'(15'(d) * 15'd100);
		sat_den_s2 <= mx_s1;
		val_s2     <= val_sum[14:8];
	end

	logic [DIV_QW-1:0] hue_q;
	logic [DIV_QW-1:0] sat_q;

	rsv_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s2),
		.hue_num   (hue_num_s2),
		.hue_den   (hue_den_s2),
		.sat_num   (sat_num_s2),
		.sat_den   (sat_den_s2),
		.val_in    (val_s2),
		.out_valid (done),
		.hue_q     (hue_q),
		.sat_q     (sat_q),
		.val_out   (val_pct)
	);

	assign hue_deg = hue_q[HUE_W-1:0];
	assign sat_pct = sat_q[PCT_W-1:0];

	a_done_lat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without request");

	a_hue_rng: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (hue_deg < 9'd360) && (sat_q[DIV_QW-1:PCT_W] == '0))
		else $error("hue or saturation quotient out of range");

	a_pct_rng: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (sat_pct <= 7'd100) && (val_pct <= 7'd100))
		else $error("percent out of range");

endmodule

### dv/rgb_to_hsv_converter_unit_tb.sv
module rgb_to_hsv_converter_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rsv_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int PIPE_LATENCY  = 11;
	localparam int MAX_REPORTS   = 40;

	typedef struct packed {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
	} pixel_t;

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [PCT_W-1:0] sat;
		logic [PCT_W-1:0] val;
	} hsv_t;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [CH_W-1:0]  red_in;
	logic [CH_W-1:0]  green_in;
	logic [CH_W-1:0]  blue_in;
	logic             done;
	logic [HUE_W-1:0] hue_deg;
	logic [PCT_W-1:0] sat_pct;
	logic [PCT_W-1:0] val_pct;

	hsv_t pending_hsv[$];
	hsv_t want_hsv;
	int   cycle_count;
	int   fail_count;
	int   pixels_sent;
	int   results_checked;
	int   gray_pixels;
	int   tied_pixels;

	rgb_to_hsv_converter_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.red_in   (red_in),
		.green_in (green_in),
		.blue_in  (blue_in),
		.done     (done),
		.hue_deg  (hue_deg),
		.sat_pct  (sat_pct),
		.val_pct  (val_pct)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic hsv_t hsv_of(pixel_t px);
		int       r;
		int       g;
		int       b;
		int       mx;
		int       mn;
		int       span;
		int       num;
		int       base;
		int       n;
		sector_t  sec;
		hsv_t     res;
		r = int'(px.r);
		g = int'(px.g);
		b = int'(px.b);
		mx = r;
		mn = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		span = mx - mn;
		if (b == mx) sec = SEC_BLUE;
		else if (g == mx) sec = SEC_GREEN;
		else sec = SEC_RED;
		case (sec)
			SEC_BLUE: begin
				num  = r - g;
				base = 240;
			end
			SEC_GREEN: begin
				num  = b - r;
				base = 120;
			end
			default: begin
				num  = g - b;
				base = 0;
			end
		endcase
		if (span == 0) begin
			res.hue = '0;
		end else begin
			n = 60 * num + base * span;
			if (n < 0) n += 360 * span;
			res.hue = HUE_W'(n / span);
		end
		res.sat = (mx == 0) ? '0 : PCT_W'((100 * span) / mx);
		res.val = PCT_W'((100 * mx) / 255);
		return res;
	endfunction

	function automatic pixel_t random_pixel();
		pixel_t px;
		int     top;
		int     lo;
		int     pick;
		px = pixel_t'($urandom);
		case ($urandom_range(0, 9))
			4: begin
				px.g = px.r;
				px.b = px.r;
			end
			5: begin
				top  = $urandom_range(0, 255);
				lo   = $urandom_range(0, top);
				pick = $urandom_range(0, 2);
				px.r = (pick == 0) ? CH_W'(lo) : CH_W'(top);
				px.g = (pick == 1) ? CH_W'(lo) : CH_W'(top);
				px.b = (pick == 2) ? CH_W'(lo) : CH_W'(top);
			end
			6: begin
				px.r = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
				px.g = ($urandom_range(0, 1) != 0) ? 8'hFE : 8'h01;
				px.b = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
				if ($urandom_range(0, 1) != 0) px = {px.g, px.b, px.r};
			end
			7: begin
				top  = $urandom_range(2, 253);
				px.r = CH_W'(top + $urandom_range(0, 4) - 2);
				px.g = CH_W'(top + $urandom_range(0, 4) - 2);
				px.b = CH_W'(top + $urandom_range(0, 4) - 2);
			end
			8: begin
				px.r = CH_W'($urandom_range(0, 3));
				px.g = CH_W'($urandom_range(0, 3));
				px.b = CH_W'($urandom_range(0, 3));
			end
			default: ;
		endcase
		return px;
	endfunction

	task automatic send_pixel(input pixel_t px);
		bit taken;
		int mx;
		taken = 1'b0;
		@(negedge clk);
		start    <= 1'b1;
		red_in   <= px.r;
		green_in <= px.g;
		blue_in  <= px.b;
		while (!taken) begin
			@(posedge clk);
			taken = !busy;
		end
		pending_hsv.push_back(hsv_of(px));
		pixels_sent++;
		mx = (px.r > px.g) ? px.r : px.g;
		if (px.b > mx) mx = px.b;
		if (px.r == px.g && px.g == px.b) gray_pixels++;
		else if ((px.r == mx) + (px.g == mx) + (px.b == mx) > 1) tied_pixels++;
	endtask

	task automatic idle_cycles(input int n);
		repeat (n) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	task automatic wait_drained();
		idle_cycles(1);
		while (pending_hsv.size() != 0) @(posedge clk);
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			if (fail_count < MAX_REPORTS)
				$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t ns: timeout with %0d results outstanding", $time, pending_hsv.size());
			$display("Verification failed");
			$finish;
		end else if (arst_n && done) begin
			if (pending_hsv.size() == 0) begin
				if (fail_count < MAX_REPORTS)
					$display("%0t ns: unexpected result, expected none, got %0d/%0d/%0d",
						$time, hue_deg, sat_pct, val_pct);
				fail_count++;
			end else begin
				want_hsv = pending_hsv.pop_front();
				check_field("hue_deg", want_hsv.hue, hue_deg);
				check_field("sat_pct", want_hsv.sat, sat_pct);
				check_field("val_pct", want_hsv.val, val_pct);
				results_checked++;
			end
		end
	end

	// corners: black, white, primaries, every tie pattern, hue wrap below zero
	task automatic test_directed_pixels();
		pixel_t corner[$];
		corner = '{
			{8'd0,   8'd0,   8'd0},   {8'd255, 8'd255, 8'd255}, {8'd128, 8'd128, 8'd128},
			{8'd1,   8'd1,   8'd1},   {8'd255, 8'd0,   8'd0},   {8'd0,   8'd255, 8'd0},
			{8'd0,   8'd0,   8'd255}, {8'd255, 8'd255, 8'd0},   {8'd0,   8'd255, 8'd255},
			{8'd255, 8'd0,   8'd255}, {8'd255, 8'd0,   8'd1},   {8'd200, 8'd10,  8'd20},
			{8'd1,   8'd0,   8'd0},   {8'd0,   8'd1,   8'd0},   {8'd0,   8'd0,   8'd1},
			{8'd255, 8'd254, 8'd253}, {8'd254, 8'd255, 8'd255}, {8'd100, 8'd100, 8'd50},
			{8'd50,  8'd100, 8'd100}, {8'd100, 8'd50,  8'd100}, {8'd170, 8'd85,  8'd0},
			{8'd1,   8'd255, 8'd0},   {8'd0,   8'd1,   8'd255}, {8'd255, 8'd1,   8'd0}
		};
		foreach (corner[i]) send_pixel(corner[i]);
	endtask

	task automatic test_random_bursts(input int count);
		int left;
		int burst;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 40);
			if (burst > left) burst = left;
			repeat (burst) send_pixel(random_pixel());
			left -= burst;
			if ($urandom_range(0, 3) != 0) idle_cycles($urandom_range(1, 14));
		end
	endtask

	task automatic test_drain_pause();
		repeat (30) send_pixel(random_pixel());
		wait_drained();
		idle_cycles($urandom_range(1, 5));
		repeat (20) send_pixel(random_pixel());
	endtask

	task automatic test_back_to_back(input int count);
		repeat (count) send_pixel(random_pixel());
	endtask

	initial begin
		arst_n   = 1'b0;
		start    = 1'b0;
		red_in   = '0;
		green_in = '0;
		blue_in  = '0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		test_directed_pixels();
		test_random_bursts(900);
		test_drain_pause();
		test_back_to_back(400);
		test_random_bursts(380);

		wait_drained();
		repeat (PIPE_LATENCY + 4) @(posedge clk);

		$display("Converted %0d pixels (%0d gray, %0d with tied maximum), %0d results checked,",
			pixels_sent, gray_pixels, tied_pixels, results_checked);
		$display("random bursts and gaps, one drained pause and a long back-to-back stream.");
		if (fail_count == 0 && pending_hsv.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
